// File: rtl/core/bphd_pkg.sv
// bphd_pkg: shared types and constants for the button press/hold detector
// no dependencies; imported by every module of the block

package bphd_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned HeldW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPressedLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHoldThreshold  = 2'd2;

  // reset values
  localparam logic            PressedLevelRst = 1'b0;
  localparam logic [ThrW-1:0] PressThrRst     = 16'd50;
  localparam logic [ThrW-1:0] HoldThrRst      = 16'd1000;

  // event kinds
  localparam logic KindPress = 1'b0;
  localparam logic KindHold  = 1'b1;

  // held time saturation point
  localparam logic [HeldW-1:0] HeldSat = 17'h1_0000;

  typedef struct packed {
    logic            pressed_level;
    logic [ThrW-1:0] press_thr;
    logic [ThrW-1:0] hold_thr;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [HeldW-1:0] held;
  } evt_t;

endpackage

// File: rtl/core/bphd_detector.sv
// bphd_detector: tick counter, press start and phase register of the detector
// depends on bphd_pkg

module bphd_detector import bphd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic level_i,
  input  cfg_t cfg_i,
  output evt_t evt_o
);

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhPressed = 3'd1,
    PhPressOk = 3'd2,
    PhHoldOk  = 3'd3,
    PhRelease = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [TickW-1:0]  start_q, start_d;
  logic [TickW-1:0]  held;
  logic [HeldW-1:0]  held_sat;
  logic              pressed;

  assign pressed  = (level_i == cfg_i.pressed_level);
  assign tick_d   = tick_q + 32'd1;
  assign held     = tick_d - start_q;
  assign held_sat = (held > {15'd0, HeldSat}) ? HeldSat : held[HeldW-1:0];

  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    evt_o.valid = 1'b0;
    evt_o.kind  = KindPress;
    evt_o.held  = held_sat;
    case (phase_q)
      PhIdle: begin
        if (pressed) begin
          start_d = tick_d;
          phase_d = PhPressed;
        end
      end
      PhPressed: begin
        if (!pressed) begin
          phase_d = PhRelease;
        end else if (held > {16'd0, cfg_i.press_thr}) begin
          phase_d     = PhPressOk;
          evt_o.valid = 1'b1;
        end
      end
      PhPressOk: begin
        if (!pressed) begin
          phase_d = PhRelease;
        end else if (held > {16'd0, cfg_i.hold_thr}) begin
          phase_d     = PhHoldOk;
          evt_o.valid = 1'b1;
          evt_o.kind  = KindHold;
        end
      end
      PhHoldOk: begin
        if (!pressed) begin
          phase_d = PhRelease;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      start_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      start_q <= start_d;
    end
  end

endmodule

// File: rtl/core/button_press_hold_detector.sv
// button_press_hold_detector: top level, handshakes, config registers, result register
// depends on bphd_pkg and bphd_detector

// Each request on the input channel is one millisecond tick carrying the
// sampled button level. The block counts ticks, notes the tick at which a
// press starts and reports a press event (event_kind 0) once the button has
// been held longer than press_threshold ticks, then a hold event (event_kind 1)
// once it has been held longer than hold_threshold ticks; held_ticks gives the
// time since the press started, saturated at 65536. Any release passes through
// a one-tick release phase back to idle. Timing: a request is taken into an
// input register; once the result register is free the detector steps its
// state with it and, if an event fires, loads the result register. The block
// takes one request every cycle unless a result register that stays full
// stops the flow, and even then the input register still takes one more
// request. Configuration is written through a plain write port (index 0
// pressed_level, 1 press_threshold, 2 hold_threshold; index 3 is ignored); the
// user writes it only while the block is idle; the block does not enforce it.

module button_press_hold_detector import bphd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tick requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               button_level_i,
  // events
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               event_kind_o,
  output logic [HeldW-1:0]   held_ticks_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t             cfg_q;
  logic             in_vld_q;
  logic             level_q;
  logic             out_vld_q;
  logic             kind_q;
  logic [HeldW-1:0] held_q;
  logic             advance;
  logic             in_take;
  evt_t             evt;

  // the request in the input register moves on once the result slot is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // config registers, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressed_level <= PressedLevelRst;
      cfg_q.press_thr     <= PressThrRst;
      cfg_q.hold_thr      <= HoldThrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPressedLevel:   cfg_q.pressed_level <= cfg_data_i[0];
        RegPressThreshold: cfg_q.press_thr     <= cfg_data_i;
        RegHoldThreshold:  cfg_q.hold_thr      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q <= button_level_i;
    end
  end

  bphd_detector u_detector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (level_q),
    .cfg_i   (cfg_q),
    .evt_o   (evt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= evt.valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt.valid) begin
      kind_q <= evt.kind;
      held_q <= evt.held;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = kind_q;
  assign held_ticks_o = held_q;

endmodule

// File: rtl/core/bphd_checker.sv
// bphd_checker: port-level assertions for the button press/hold detector
// depends on bphd_pkg; bound to button_press_hold_detector

module bphd_checker import bphd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             event_kind_o,
  input logic [HeldW-1:0] held_ticks_o
);

  // an event always comes after at least one held tick, never past saturation
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (held_ticks_o != '0) && (held_ticks_o <= HeldSat))
    else $error("held_ticks out of range");

  // a free output side never stalls the input side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output ready");

  // no event can be pending right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("event shown right after reset");

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(held_ticks_o))
    else $error("stalled event changed");

endmodule

bind button_press_hold_detector bphd_checker u_bphd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_kind_o (event_kind_o),
  .held_ticks_o (held_ticks_o)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for button_press_hold_detector, tick requests in, events out
// depends on bphd_pkg and the block's rtl; predicts events with its own detector copy

module tb_top;
  import bphd_pkg::*;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainGuard    = 20000;
  localparam int unsigned RandomTicks   = 290;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // detector phases, as the block steps through them
  typedef enum logic [2:0] {
    DetIdle    = 3'd0,
    DetPressed = 3'd1,
    DetPressOk = 3'd2,
    DetHoldOk  = 3'd3,
    DetRelease = 3'd4
  } det_phase_e;

  typedef struct packed {
    logic             kind;
    logic [HeldW-1:0] held;
  } button_event_t;

  // clock, reset and block ports
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               button_level_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               event_kind_o;
  logic [HeldW-1:0]   held_ticks_o;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i    = RegPressedLevel;
  logic [CfgW-1:0]    cfg_data_i     = '0;

  // stimulus and checking state
  logic          level_queue[$];     // tick requests waiting to be offered
  button_event_t pending_events[$];  // events predicted but not yet seen
  int unsigned   ticks_queued   = 0;
  int unsigned   ticks_taken    = 0;
  int unsigned   mismatch_count = 0;
  logic          tick_taken_q   = 1'b0;
  int unsigned   tx_idle_pct    = 0;
  int unsigned   rx_stall_pct   = 0;
  logic          hold_start     = 1'b0;
  logic          rx_hold        = 1'b0;

  // our own copy of the detector: settings and state
  logic              level_cfg     = PressedLevelRst;
  logic [ThrW-1:0]   press_thr_cfg = PressThrRst;
  logic [ThrW-1:0]   hold_thr_cfg  = HoldThrRst;
  logic [TickW-1:0]  tick_cnt      = '0;
  logic [TickW-1:0]  press_tick    = '0;
  det_phase_e        det_phase     = DetIdle;

  button_press_hold_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .held_ticks_o   (held_ticks_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // queue an event, held time clipped at the saturation point
  task automatic expect_event(input logic kind, input logic [TickW-1:0] held);
    button_event_t ev;
    ev.kind = kind;
    ev.held = (held > TickW'(HeldSat)) ? HeldSat : held[HeldW-1:0];
    pending_events.push_back(ev);
  endtask

  // one millisecond tick through the detector copy
  task automatic step_detector(input logic level);
    logic             is_pressed;
    logic [TickW-1:0] held;
    is_pressed = (level == level_cfg);
    tick_cnt   = tick_cnt + 1'b1;
    // wrapped difference, compared at full width against the thresholds
    held       = tick_cnt - press_tick;
    case (det_phase)
      DetIdle: begin
        if (is_pressed) begin
          press_tick = tick_cnt;
          det_phase  = DetPressed;
        end
      end
      DetPressed: begin
        if (!is_pressed) begin
          det_phase = DetRelease;
        end else if (held > TickW'(press_thr_cfg)) begin
          det_phase = DetPressOk;
          expect_event(KindPress, held);
        end
      end
      DetPressOk: begin
        // a hold threshold below the press threshold fires on the very next tick
        if (!is_pressed) begin
          det_phase = DetRelease;
        end else if (held > TickW'(hold_thr_cfg)) begin
          det_phase = DetHoldOk;
          expect_event(KindHold, held);
        end
      end
      DetHoldOk: begin
        if (!is_pressed) det_phase = DetRelease;
      end
      // release lasts one tick whatever the level; stray codes fall back to idle
      default: det_phase = DetIdle;
    endcase
  endtask

  // monitor: predict on every accepted tick request, check every accepted event
  always @(posedge clk_i) begin : monitor_proc
    button_event_t exp_ev;
    if (rst_ni) begin
      tick_taken_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        step_detector(button_level_i);
        ticks_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_events.size() == 0) begin
          note_mismatch($sformatf("unexpected event kind %0d held %0d",
                                  event_kind_o, held_ticks_o));
        end else begin
          exp_ev = pending_events.pop_front();
          if (event_kind_o !== exp_ev.kind || held_ticks_o !== exp_ev.held)
            note_mismatch($sformatf("event kind %0d held %0d, expected kind %0d held %0d",
                                    event_kind_o, held_ticks_o, exp_ev.kind, exp_ev.held));
        end
      end
    end
  end

  // driver: offers queued tick requests and drives the event ready, both at the falling edge
  always @(negedge clk_i) begin : driver_proc
    logic tx_valid;
    logic tx_level;
    if (rst_ni) begin
      tx_valid = in_valid_i;
      tx_level = button_level_i;
      // the request on the port went in at the last rising edge
      if (in_valid_i && tick_taken_q) tx_valid = 1'b0;
      if (!tx_valid && level_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        tx_level = level_queue.pop_front();
        tx_valid = 1'b1;
      end
      in_valid_i     <= tx_valid;
      button_level_i <= tx_level;
      out_ready_i    <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the sender keeps pushing and the block backs up
  initial begin
    wait (hold_start);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldOffCycles) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("button_press_hold_detector regression: fail");
    $finish;
  end

  task automatic queue_level(input logic level, input int unsigned count);
    repeat (count) begin
      level_queue.push_back(level);
      ticks_queued++;
    end
  endtask

  // every request taken and every event seen, then room for a tick still in flight
  task automatic wait_quiet();
    while (ticks_taken != ticks_queued || pending_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegPressedLevel:   level_cfg     = data[0];
      RegPressThreshold: press_thr_cfg = data;
      RegHoldThreshold:  hold_thr_cfg  = data;
      default: ;  // unused index, nothing changes
    endcase
  endtask

  // new settings once the block is quiet; upper bits of the level write are junk
  task automatic apply_settings(input logic level, input logic [ThrW-1:0] press_thr,
                                input logic [ThrW-1:0] hold_thr);
    logic [CfgW-1:0] level_word;
    wait_quiet();
    level_word    = CfgW'($urandom);
    level_word[0] = level;
    write_reg(RegUnused, CfgW'($urandom));
    write_reg(RegPressedLevel, level_word);
    write_reg(RegPressThreshold, press_thr);
    write_reg(RegHoldThreshold, hold_thr);
  endtask

  // mostly clean presses around the thresholds, some cut short, some noise
  task automatic queue_random_ticks(input int unsigned count);
    int unsigned start_cnt;
    int unsigned pick;
    int unsigned run_len;
    start_cnt = ticks_queued;
    while (ticks_queued - start_cnt < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        run_len = $urandom_range(1, int'(hold_thr_cfg) + 4);
        queue_level(level_cfg, run_len);
        queue_level(!level_cfg, $urandom_range(1, 3));
      end else if (pick < 9) begin
        run_len = $urandom_range(1, int'(press_thr_cfg) + 1);
        queue_level(level_cfg, run_len);
        queue_level(!level_cfg, 1);
      end else begin
        repeat ($urandom_range(1, 8)) queue_level(1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    apply_settings(1'($urandom_range(0, 1)), ThrW'($urandom_range(0, 6)),
                   ThrW'($urandom_range(0, 12)));
    @(negedge clk_i);
    tx_idle_pct  <= tx_pct;
    rx_stall_pct <= rx_pct;
    queue_random_ticks(RandomTicks);
  endtask

  initial begin : sequencer
    int unsigned guard;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: low level presses, press event once held past 50 ticks
    queue_level(1'b0, 52);
    queue_level(1'b1, 2);

    // lowest thresholds, high level presses
    apply_settings(1'b1, 16'd0, 16'd0);
    queue_level(1'b0, 1);   // idle, not pressed
    queue_level(1'b1, 4);   // press start, press event, hold event, stay held
    queue_level(1'b0, 1);   // release from hold confirmed
    queue_level(1'b1, 2);   // level ignored in release, then a new press starts
    queue_level(1'b0, 2);   // release straight from pressed, back to idle
    queue_level(1'b1, 2);   // press and its event
    queue_level(1'b0, 2);   // release from press confirmed

    // hold threshold below press threshold: hold right after press
    apply_settings(1'b1, 16'd2, 16'd1);
    queue_level(1'b1, 5);
    queue_level(1'b0, 1);

    // random presses under each idling pattern
    run_random_phase(0, 0);
    run_random_phase(78, 0);
    run_random_phase(0, 78);
    run_random_phase(34, 34);

    // back-pressure: dense events while the receiver holds off
    apply_settings(1'($urandom_range(0, 1)), 16'd0, 16'd0);
    @(negedge clk_i);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    hold_start   <= 1'b1;
    repeat (30) begin
      queue_level(level_cfg, 3);
      queue_level(!level_cfg, 2);
    end

    // drain, bounded
    guard = 0;
    while ((ticks_taken != ticks_queued || pending_events.size() != 0) && guard < DrainGuard) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (pending_events.size() != 0)
      note_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    if (ticks_taken != ticks_queued)
      note_mismatch($sformatf("%0d tick requests never taken", ticks_queued - ticks_taken));

    if (mismatch_count == 0) begin
      $display("button_press_hold_detector regression: pass");
    end else begin
      $display("button_press_hold_detector regression: fail");
    end
    $finish;
  end

endmodule
